/* hw/rtl/ptw_pkg.sv */
// Shared types and constants for the four-level page table walker.
// Used by ptw_step and four_level_page_table_walker_top; depends on nothing.
package ptw_pkg;

	localparam int VA_W    = 48;
	localparam int ADDR_W  = 64;
	localparam int FRAME_W = 52;
	localparam int IDX_W   = 9;
	localparam int OFS_W   = 12;

	// Input opcodes, carried on s_tuser.
	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_RESPONSE  = 1'b1;

	// Result kinds, carried on m_tuser.
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] LVL_ROOT = 2'd0;
	localparam logic [1:0] LVL_L1   = 2'd1;
	localparam logic [1:0] LVL_L2   = 2'd2;
	localparam logic [1:0] LVL_LEAF = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [VA_W-1:0]   vaddr;
		logic [ADDR_W-1:0] read_data;
	} ptw_item_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] read_addr;
		logic [ADDR_W-1:0] frame_base;
		logic              fault;
		logic [1:0]        fault_level;
	} ptw_res_t;

	typedef struct packed {
		logic            busy;
		logic [1:0]      level;
		logic [VA_W-1:0] vaddr;
	} ptw_walk_t;

	// Nine-bit table index for a level: bits 47:39, 38:30, 29:21 or 20:12.
	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			LVL_ROOT: idx = va[47:39];
			LVL_L1:   idx = va[38:30];
			LVL_L2:   idx = va[29:21];
			LVL_LEAF: idx = va[20:12];
			default:  idx = '0;
		endcase
		return idx;
	endfunction

	// Entry address: the table base is page aligned, so the index just fills bits 11:3.
	function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-OFS_W-1:0] base_hi,
		input logic [IDX_W-1:0] idx);
		return {base_hi, idx, 3'b000};
	endfunction

endpackage

/* hw/rtl/four_level_page_table_walker_top.sv */
// Four-level page table walker, top level: input register, step logic and
// result register. Depends on ptw_pkg and ptw_step.
//
// Usage: a transfer on the slave side is either a translate request
// (s_tuser = 0, virtual address in s_tdata) or a memory read response
// (s_tuser = 1, 64-bit table entry in s_tdata). Each request yields a read
// request for the root entry on the master side (m_tuser = 0). Each response
// yields the next read request, or the end of the walk (m_tuser = 1) with the
// page-frame base or a fault and its level. A response while no walk is
// active yields nothing. A request during a walk abandons that walk.
// root_frame is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. m_tvalid
// rises once an item has passed the input and result registers; one item is
// accepted per cycle unless the receiver stalls, via the single step stage.
// When the receiver stalls, the result register holds and the input register
// fills, after which s_tready drops. Reset empties both registers, clears the
// walk state to idle and sets root_frame to zero.
module four_level_page_table_walker_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // vaddr[47:0], read_data[111:48]
	input  logic         s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // read_addr[63:0], frame_base[127:64], fault[128],
	                                // fault_level[130:129], zero pad[135:131]
	output logic         m_tuser,   // kind
	input  logic         cfg_we,
	input  logic [51:0]  cfg_wdata  // root_frame
);
	import ptw_pkg::*;

	logic            valid_s1;
	ptw_item_t       item_s1;
	logic            valid_s2;
	ptw_res_t        res_s2;
	ptw_walk_t       walk_q;
	logic [FRAME_W-1:0] root_q;

	logic            adv_s1;
	logic            has_result;
	ptw_res_t        res_next;
	ptw_walk_t       walk_next;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode    <= s_tuser;
			item_s1.vaddr     <= s_tdata[47:0];
			item_s1.read_data <= s_tdata[111:48];
		end
	end

	ptw_step u_step (
		.item       (item_s1),
		.walk       (walk_q),
		.root_frame (root_q),
		.has_result (has_result),
		.res        (res_next),
		.walk_next  (walk_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
			root_q <= '0;
		end else begin
			if (adv_s1) begin
				walk_q <= walk_next;
			end
			if (cfg_we) begin
				root_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= has_result;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {5'b00000, res_s2.fault_level, res_s2.fault,
		res_s2.frame_base, res_s2.read_addr};

endmodule

/* hw/rtl/ptw_step.sv */
// One walk step: takes the current walk state and one input item and forms
// the result and the next walk state. Pure combinational; depends on ptw_pkg.
module ptw_step (
	input  ptw_pkg::ptw_item_t              item,
	input  ptw_pkg::ptw_walk_t              walk,
	input  logic [ptw_pkg::FRAME_W-1:0]     root_frame,
	output logic                            has_result,
	output ptw_pkg::ptw_res_t               res,
	output ptw_pkg::ptw_walk_t              walk_next
);
	import ptw_pkg::*;

	logic [1:0] next_level;
	logic       table_ok;

	assign next_level = walk.level + 2'd1;
	assign table_ok   = item.read_data[0] && item.read_data[1];

	always_comb begin
		has_result = 1'b0;
		res        = '0;
		walk_next  = walk;
		if (item.opcode == OP_TRANSLATE) begin
			// A new request drops any walk in progress.
			has_result      = 1'b1;
			walk_next.busy  = 1'b1;
			walk_next.level = LVL_ROOT;
			walk_next.vaddr = item.vaddr;
			res.kind        = KIND_READ;
			res.read_addr   = entry_addr(root_frame, level_index(item.vaddr, LVL_ROOT));
		end else if (walk.busy) begin
			has_result = 1'b1;
			if (walk.level != LVL_LEAF) begin
				if (table_ok) begin
					walk_next.level = next_level;
					res.kind        = KIND_READ;
					res.read_addr   = entry_addr(item.read_data[ADDR_W-1:OFS_W],
						level_index(walk.vaddr, next_level));
				end else begin
					walk_next.busy  = 1'b0;
					walk_next.level = LVL_ROOT;
					res.kind        = KIND_DONE;
					res.fault       = 1'b1;
					res.fault_level = walk.level;
				end
			end else begin
				walk_next.busy  = 1'b0;
				walk_next.level = LVL_ROOT;
				res.kind        = KIND_DONE;
				if (item.read_data[0]) begin
					res.frame_base = {item.read_data[ADDR_W-1:OFS_W], {OFS_W{1'b0}}};
				end else begin
					res.fault       = 1'b1;
					res.fault_level = LVL_LEAF;
				end
			end
		end
	end

endmodule
